// ===== design/mrfc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Modbus RTU frame checker package
// Shared types, constants and the CRC-16 byte update.
// ----------------------------------------------------------------------------
package mrfc_pkg;

  localparam int MAX_FRAME_BYTES = 256;
  localparam int MIN_FRAME_BYTES = 5;
  localparam int COUNT_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int PAD_W = 3;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_TOO_SHORT = 2'd1;
  localparam logic [1:0] STATUS_CRC_ERR = 2'd2;

  typedef struct packed {
    logic [7:0]       data;
    logic             eof;
    logic             kept;
    logic             crc_en;
    logic             emit;
    logic             too_short;
    logic [PAD_W-1:0] pad;
  } item_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== design/mrfc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Modbus RTU frame checker front end
// Accepts received bytes, tracks the frame position and classifies each byte.
// ----------------------------------------------------------------------------
module mrfc_front import mrfc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  input  wire logic       end_of_frame,
  input  wire logic       q_full,
  output logic            push,
  output item_t           push_item
);

  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic               kept;
  logic [COUNT_W:0]   after_count;
  logic               short_frame;

  assign in_ready = !q_full;
  assign push = in_valid && in_ready;
  assign kept = ({1'b0, count} < (COUNT_W + 1)'(MAX_FRAME_BYTES));
  assign after_count = kept ? ({1'b0, count} + (COUNT_W + 1)'(1)) : {1'b0, count};
  assign short_frame = (after_count < (COUNT_W + 1)'(MIN_FRAME_BYTES));

  always_comb begin
    push_item.data = rx_byte;
    push_item.eof = end_of_frame;
    push_item.kept = kept;
    push_item.crc_en = (count >= COUNT_W'(2));
    push_item.emit = (count >= COUNT_W'(3));
    push_item.too_short = short_frame;
    if (short_frame) begin
      push_item.pad = PAD_W'((COUNT_W + 1)'(MIN_FRAME_BYTES) - after_count);
    end else begin
      push_item.pad = '0;
    end
  end

  always_comb begin
    count_next = count;
    if (push) begin
      if (end_of_frame) begin
        count_next = '0;
      end else begin
        count_next = after_count[COUNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule
`default_nettype wire

// ===== design/mrfc_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Modbus RTU frame checker queue
// Short first-in first-out buffer of classified bytes between front and back.
// ----------------------------------------------------------------------------
module mrfc_queue import mrfc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  item_t     push_item,
  output logic      full,
  input  wire logic pop,
  output logic      not_empty,
  output item_t     head
);

  item_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;
  logic              do_push;
  logic              do_pop;

  assign full = (fill == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign head = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + (QPTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - (QPTR_W + 1)'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/mrfc_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Modbus RTU frame checker back end
// Runs the two-byte delay, padding and CRC, and drives the result register.
// ----------------------------------------------------------------------------
module mrfc_back import mrfc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_not_empty,
  input  item_t     q_head,
  output logic      pop,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic       out_kind,
  output logic [7:0] payload_byte,
  output logic [1:0] frame_status,
  output logic       last_of_run
);

  typedef enum logic [1:0] {
    ST_ITEM,
    ST_PAD,
    ST_STATUS
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [15:0]      crc;
  logic [15:0]      crc_next;
  logic [7:0]       held0;
  logic [7:0]       held0_next;
  logic [7:0]       held1;
  logic [7:0]       held1_next;
  logic [PAD_W-1:0] pad;
  logic [PAD_W-1:0] pad_next;
  logic             too_short;
  logic             too_short_next;
  logic             out_valid_next;
  logic             out_kind_next;
  logic [7:0]       payload_byte_next;
  logic [1:0]       frame_status_next;
  logic             last_of_run_next;
  logic             adv;
  logic [15:0]      crc_upd;
  logic             mismatch;

  assign adv = !out_valid || out_ready;
  assign crc_upd = crc16_byte(crc, held0);
  assign mismatch = ({held0, held1} != {crc[7:0], crc[15:8]});

  always_comb begin
    state_next = state;
    crc_next = crc;
    held0_next = held0;
    held1_next = held1;
    pad_next = pad;
    too_short_next = too_short;
    out_valid_next = out_valid && !out_ready;
    out_kind_next = out_kind;
    payload_byte_next = payload_byte;
    frame_status_next = frame_status;
    last_of_run_next = last_of_run;
    pop = 1'b0;
    case (state)
      ST_ITEM: begin
        if (adv && q_not_empty) begin
          pop = 1'b1;
          if (q_head.kept) begin
            held0_next = held1;
            held1_next = q_head.data;
            if (q_head.crc_en) begin
              crc_next = crc_upd;
            end
            if (q_head.emit) begin
              out_valid_next = 1'b1;
              out_kind_next = KIND_PAYLOAD;
              payload_byte_next = held0;
              frame_status_next = STATUS_OK;
              last_of_run_next = !q_head.eof;
            end
          end
          if (q_head.eof) begin
            too_short_next = q_head.too_short;
            pad_next = q_head.pad;
            state_next = (q_head.pad != '0) ? ST_PAD : ST_STATUS;
          end
        end
      end
      ST_PAD: begin
        if (adv) begin
          held0_next = held1;
          held1_next = 8'h00;
          if (pad <= PAD_W'(3)) begin
            crc_next = crc_upd;
          end
          if (pad <= PAD_W'(2)) begin
            out_valid_next = 1'b1;
            out_kind_next = KIND_PAYLOAD;
            payload_byte_next = held0;
            frame_status_next = STATUS_OK;
            last_of_run_next = 1'b0;
          end
          pad_next = pad - PAD_W'(1);
          if (pad == PAD_W'(1)) begin
            state_next = ST_STATUS;
          end
        end
      end
      ST_STATUS: begin
        if (adv) begin
          out_valid_next = 1'b1;
          out_kind_next = KIND_STATUS;
          payload_byte_next = 8'h00;
          if (mismatch) begin
            frame_status_next = STATUS_CRC_ERR;
          end else if (too_short) begin
            frame_status_next = STATUS_TOO_SHORT;
          end else begin
            frame_status_next = STATUS_OK;
          end
          last_of_run_next = 1'b1;
          crc_next = CRC_INIT;
          held0_next = 8'h00;
          held1_next = 8'h00;
          too_short_next = 1'b0;
          state_next = ST_ITEM;
        end
      end
      default: begin
        state_next = ST_ITEM;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ITEM;
      crc <= CRC_INIT;
      held0 <= 8'h00;
      held1 <= 8'h00;
      pad <= '0;
      too_short <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      crc <= crc_next;
      held0 <= held0_next;
      held1 <= held1_next;
      pad <= pad_next;
      too_short <= too_short_next;
      out_valid <= out_valid_next;
    end
    out_kind <= out_kind_next;
    payload_byte <= payload_byte_next;
    frame_status <= frame_status_next;
    last_of_run <= last_of_run_next;
  end

endmodule
`default_nettype wire

// ===== design/modbus_rtu_frame_checker.sv =====
`default_nettype none
// A byte's transaction is queued at acceptance; the back end pops it and registers its result
// at the same edge, so a result passes through the queue entry and then the output register.
// Throughput is one byte per cycle while out_ready holds and no pad or status state runs, set
// by the single CRC byte update in the back end. After a frame's final byte the back end runs
// its pad state once per padding byte, then its status state. Synchronous reset empties the
// queue and returns the CRC, position count and delay bytes to their start-of-frame values.
// ----------------------------------------------------------------------------
// Modbus RTU frame checker
// Strips the address and CRC from a serial frame, checks the CRC and reports.
// ----------------------------------------------------------------------------
module modbus_rtu_frame_checker import mrfc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  input  wire logic       end_of_frame,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_kind,
  output logic [7:0]      payload_byte,
  output logic [1:0]      frame_status,
  output logic            last_of_run
);

  logic  q_full;
  logic  push;
  item_t push_item;
  logic  pop;
  logic  q_not_empty;
  item_t q_head;

  mrfc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .end_of_frame (end_of_frame),
    .q_full       (q_full),
    .push         (push),
    .push_item    (push_item)
  );

  mrfc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  mrfc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_not_empty  (q_not_empty),
    .q_head       (q_head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .payload_byte (payload_byte),
    .frame_status (frame_status),
    .last_of_run  (last_of_run)
  );

endmodule
`default_nettype wire
